>>> sv/segment_rect_clip_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the segment rectangle clipper
// Wraps concurrent assertions so that synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_RECT_CLIP_UNIT_ASSERT_SVH
`define SEGMENT_RECT_CLIP_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Checks a property on every clock edge outside of reset.
`define SRCLIP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks a property on every clock edge, including during reset.
`define SRCLIP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRCLIP_ASSERT(label, prop, msg)
`define SRCLIP_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> sv/srclip_pkg.sv
// ----------------------------------------------------------------------------
// Segment rectangle clipper package
// Default widths, register indexes and reset values shared by the clipper.
// ----------------------------------------------------------------------------
package srclip_pkg;

    // Default coordinate width (Q12.4) and parameter fraction width.
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Quotient bits resolved per divider pipeline stage.
    localparam int DIV_STEPS_PER_STAGE = 4;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 2;
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WIN_LEFT   = 2'd0,
        REG_WIN_TOP    = 2'd1,
        REG_WIN_RIGHT  = 2'd2,
        REG_WIN_BOTTOM = 2'd3
    } cfg_reg_t;

    // Window reset values.
    localparam int WIN_LOW_RESET  = 0;
    localparam int WIN_HIGH_RESET = 32767;

    // Edge order of the clip tests.
    localparam int EDGE_LEFT   = 0;
    localparam int EDGE_RIGHT  = 1;
    localparam int EDGE_TOP    = 2;
    localparam int EDGE_BOTTOM = 3;
    localparam int NUM_EDGES   = 4;

endpackage

>>> sv/segment_rect_clip_unit.sv
// ----------------------------------------------------------------------------
// Segment rectangle clipper
// Liang-Barsky clipping of 2D segments against a window held in registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one segment per transaction
//   (start_x, start_y, end_x, end_y, signed Q12.4). Output channel
//   out_valid/out_ready carries one result per transaction: visible and the
//   clipped endpoints; a rejected segment returns its input endpoints.
//   The window is set through cfg_write/cfg_index/cfg_data while idle.
// Timing:
//   Fully pipelined: one segment per cycle while out_ready does not stall
//   the output. The depth is set by the edge distance and magnitude stages,
//   the four parallel restoring dividers, which resolve up to four quotient
//   bits per stage, and the clamp, edge test, multiply and round stages.
// Reset and stalls:
//   Reset empties the pipeline and loads the default window (0,0)-(32767,
//   32767). When out_ready is low with a result waiting, the whole pipeline
//   holds and in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "segment_rect_clip_unit_assert.svh"

module segment_rect_clip_unit #(
    parameter int COORD_BITS = srclip_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = srclip_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [srclip_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0]                cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [COORD_BITS-1:0]         start_x,
    input  logic signed [COORD_BITS-1:0]         start_y,
    input  logic signed [COORD_BITS-1:0]         end_x,
    input  logic signed [COORD_BITS-1:0]         end_y,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 visible,
    output logic signed [COORD_BITS-1:0]         clip_start_x,
    output logic signed [COORD_BITS-1:0]         clip_start_y,
    output logic signed [COORD_BITS-1:0]         clip_end_x,
    output logic signed [COORD_BITS-1:0]         clip_end_y
);

    localparam int C          = COORD_BITS;
    localparam int F          = FRAC_BITS;
    localparam int DW         = C + 1;
    localparam int UW         = F + 3;
    localparam int MW         = F + 2;
    localparam int PW         = UW + DW;
    localparam int QBITS      = F + 1;
    localparam int STEPS      = srclip_pkg::DIV_STEPS_PER_STAGE;
    localparam int DIV_STAGES = (QBITS + STEPS - 1) / STEPS;
    localparam int NE         = srclip_pkg::NUM_EDGES;

    localparam logic signed [UW-1:0] U_ZERO = '0;
    localparam logic signed [UW-1:0] U_ONE  = UW'(64'd1 << F);
    localparam logic [MW-1:0]        M_ONE  = MW'(64'd1 << F);
    localparam logic [MW-1:0]        M_TWO  = MW'(64'd1 << (F + 1));
    localparam logic [PW-1:0]        HALF   = PW'(64'd1 << (F - 1));

    typedef struct packed {
        logic signed [C-1:0]  sx;
        logic signed [C-1:0]  sy;
        logic signed [C-1:0]  ex;
        logic signed [C-1:0]  ey;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
    } coord_t;

    typedef struct packed {
        logic         pzero;
        logic         pneg;
        logic         qneg;
        logic         rneg;
        logic         ovf;
        logic [C-1:0] pmag;
    } edge_t;

    // Global advance: the pipeline moves when the output slot is free or taken.
    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // Window registers.
    logic signed [C-1:0] win_left_reg, win_top_reg, win_right_reg, win_bottom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= C'(srclip_pkg::WIN_LOW_RESET);
            win_top_reg    <= C'(srclip_pkg::WIN_LOW_RESET);
            win_right_reg  <= C'(srclip_pkg::WIN_HIGH_RESET);
            win_bottom_reg <= C'(srclip_pkg::WIN_HIGH_RESET);
        end
        else if (cfg_write)
        begin
            case (srclip_pkg::cfg_reg_t'(cfg_index))
                srclip_pkg::REG_WIN_LEFT:   win_left_reg   <= cfg_data;
                srclip_pkg::REG_WIN_TOP:    win_top_reg    <= cfg_data;
                srclip_pkg::REG_WIN_RIGHT:  win_right_reg  <= cfg_data;
                srclip_pkg::REG_WIN_BOTTOM: win_bottom_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage A: edge distances q and direction terms p.
    // ------------------------------------------------------------------
    logic                 a_vld_reg;
    coord_t               a_crd_reg, a_crd_next;
    logic signed [DW-1:0] a_q_reg [NE];
    logic signed [DW-1:0] a_p_reg [NE];
    logic signed [DW-1:0] a_q_next [NE];
    logic signed [DW-1:0] a_p_next [NE];

    always_comb
    begin
        logic signed [DW-1:0] sx, sy, ex, ey;
        sx = {start_x[C-1], start_x};
        sy = {start_y[C-1], start_y};
        ex = {end_x[C-1], end_x};
        ey = {end_y[C-1], end_y};
        a_crd_next.sx = start_x;
        a_crd_next.sy = start_y;
        a_crd_next.ex = end_x;
        a_crd_next.ey = end_y;
        a_crd_next.dx = ex - sx;
        a_crd_next.dy = ey - sy;
        a_p_next[srclip_pkg::EDGE_LEFT]   = sx - ex;
        a_q_next[srclip_pkg::EDGE_LEFT]   = sx - {win_left_reg[C-1], win_left_reg};
        a_p_next[srclip_pkg::EDGE_RIGHT]  = ex - sx;
        a_q_next[srclip_pkg::EDGE_RIGHT]  = {win_right_reg[C-1], win_right_reg} - sx;
        a_p_next[srclip_pkg::EDGE_TOP]    = sy - ey;
        a_q_next[srclip_pkg::EDGE_TOP]    = sy - {win_top_reg[C-1], win_top_reg};
        a_p_next[srclip_pkg::EDGE_BOTTOM] = ey - sy;
        a_q_next[srclip_pkg::EDGE_BOTTOM] = {win_bottom_reg[C-1], win_bottom_reg} - sy;
    end

    // ------------------------------------------------------------------
    // Divider pipeline: slot 0 holds magnitudes, later slots quotient bits.
    // ------------------------------------------------------------------
    logic         dv_vld_reg  [DIV_STAGES+1];
    coord_t       dv_crd_reg  [DIV_STAGES+1];
    edge_t        dv_edge_reg [DIV_STAGES+1][NE];
    logic [C:0]   dv_rem_reg  [DIV_STAGES+1][NE];
    logic [F:0]   dv_quot_reg [DIV_STAGES+1][NE];

    edge_t        pr_edge_next [NE];
    logic [C:0]   pr_rem_next  [NE];

    // Magnitudes, signs and the overflow check that saturates the quotient.
    always_comb
    begin
        logic [DW-1:0] pabs, qabs;
        for (int e = 0; e < NE; e++)
        begin
            pabs = a_p_reg[e][DW-1] ? DW'(-a_p_reg[e]) : DW'(a_p_reg[e]);
            qabs = a_q_reg[e][DW-1] ? DW'(-a_q_reg[e]) : DW'(a_q_reg[e]);
            pr_edge_next[e].pzero = (a_p_reg[e] == '0);
            pr_edge_next[e].pneg  = a_p_reg[e][DW-1];
            pr_edge_next[e].qneg  = a_q_reg[e][DW-1];
            pr_edge_next[e].rneg  = a_p_reg[e][DW-1] ^ a_q_reg[e][DW-1];
            pr_edge_next[e].pmag  = pabs[C-1:0];
            pr_edge_next[e].ovf   = ({1'b0, qabs[C-1:0]} >= {pabs[C-1:0], 1'b0});
            pr_rem_next[e]        = {1'b0, qabs[C-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg     <= 1'b0;
            dv_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg     <= in_valid;
            dv_vld_reg[0] <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_crd_reg     <= a_crd_next;
            dv_crd_reg[0] <= a_crd_reg;
            for (int e = 0; e < NE; e++)
            begin
                a_q_reg[e]           <= a_q_next[e];
                a_p_reg[e]           <= a_p_next[e];
                dv_edge_reg[0][e]    <= pr_edge_next[e];
                dv_rem_reg[0][e]     <= pr_rem_next[e];
                dv_quot_reg[0][e]    <= '0;
            end
        end
    end

    // Restoring division steps, a few quotient bits per stage.
    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        logic [C:0] rem_next  [NE];
        logic [F:0] quot_next [NE];

        always_comb
        begin
            logic [C:0] rem;
            logic [F:0] quot;
            logic [C:0] pm;
            for (int e = 0; e < NE; e++)
            begin
                rem  = dv_rem_reg[g][e];
                quot = dv_quot_reg[g][e];
                pm   = {1'b0, dv_edge_reg[g][e].pmag};
                for (int j = 0; j < STEPS; j++)
                begin
                    if (g * STEPS + j < QBITS)
                    begin
                        if (rem >= pm)
                        begin
                            rem  = rem - pm;
                            quot = {quot[F-1:0], 1'b1};
                        end
                        else
                        begin
                            quot = {quot[F-1:0], 1'b0};
                        end
                        rem = {rem[C-1:0], 1'b0};
                    end
                end
                rem_next[e]  = rem;
                quot_next[e] = quot;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[g+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_vld_reg[g+1] <= dv_vld_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_crd_reg[g+1] <= dv_crd_reg[g];
                for (int e = 0; e < NE; e++)
                begin
                    dv_edge_reg[g+1][e] <= dv_edge_reg[g][e];
                    dv_rem_reg[g+1][e]  <= rem_next[e];
                    dv_quot_reg[g+1][e] <= quot_next[e];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage R: signed, clamped quotients.
    // ------------------------------------------------------------------
    logic                 r_vld_reg;
    coord_t               r_crd_reg;
    edge_t                r_edge_reg [NE];
    logic signed [UW-1:0] r_u_reg    [NE];
    logic signed [UW-1:0] r_u_next   [NE];

    always_comb
    begin
        logic [MW-1:0] mag;
        for (int e = 0; e < NE; e++)
        begin
            mag = dv_edge_reg[DIV_STAGES][e].ovf ? M_TWO
                                                 : {1'b0, dv_quot_reg[DIV_STAGES][e]};
            if (dv_edge_reg[DIV_STAGES][e].rneg)
            begin
                if (mag > M_ONE)
                begin
                    r_u_next[e] = -U_ONE;
                end
                else
                begin
                    r_u_next[e] = -$signed({1'b0, mag});
                end
            end
            else
            begin
                r_u_next[e] = $signed({1'b0, mag});
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage E: the left, right, top and bottom edge tests in order, tightening u1 and u2.
    // ------------------------------------------------------------------
    logic                 e_vld_reg;
    coord_t               e_crd_reg;
    logic                 e_vis_reg, e_vis_next;
    logic signed [UW-1:0] e_u1_reg, e_u1_next;
    logic signed [UW-1:0] e_u2_reg, e_u2_next;

    always_comb
    begin
        e_vis_next = 1'b1;
        e_u1_next  = U_ZERO;
        e_u2_next  = U_ONE;
        for (int e = 0; e < NE; e++)
        begin
            if (e_vis_next)
            begin
                if (r_edge_reg[e].pzero)
                begin
                    if (r_edge_reg[e].qneg)
                    begin
                        e_vis_next = 1'b0;
                    end
                end
                else if (r_edge_reg[e].pneg)
                begin
                    if (r_u_reg[e] > e_u2_next)
                    begin
                        e_vis_next = 1'b0;
                    end
                    else if (r_u_reg[e] > e_u1_next)
                    begin
                        e_u1_next = r_u_reg[e];
                    end
                end
                else
                begin
                    if (r_u_reg[e] < e_u1_next)
                    begin
                        e_vis_next = 1'b0;
                    end
                    else if (r_u_reg[e] < e_u2_next)
                    begin
                        e_u2_next = r_u_reg[e];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage M: parameter times direction products.
    // ------------------------------------------------------------------
    logic                 m_vld_reg;
    coord_t               m_crd_reg;
    logic                 m_vis_reg;
    logic                 m_use1_reg;
    logic                 m_use2_reg;
    logic signed [PW-1:0] m_p1x_reg, m_p1y_reg, m_p2x_reg, m_p2y_reg;

    // ------------------------------------------------------------------
    // Stage O: rounding and endpoint selection into the output register.
    // ------------------------------------------------------------------
    logic                o_vld_reg;
    logic                o_vis_reg;
    logic signed [C-1:0] o_sx_reg, o_sy_reg, o_ex_reg, o_ey_reg;
    logic signed [C-1:0] o_sx_next, o_sy_next, o_ex_next, o_ey_next;

    function automatic logic signed [C-1:0] offset_point(
        input logic signed [C-1:0]  base,
        input logic signed [PW-1:0] prod
    );
        logic [PW-1:0] mag;
        logic [PW-1:0] res;
        logic [PW-1:0] sres;
        logic [PW-1:0] sum;
        mag  = prod[PW-1] ? PW'(-prod) : PW'(prod);
        res  = (mag + HALF) >> F;
        sres = prod[PW-1] ? PW'(-res) : res;
        sum  = PW'($signed(base)) + sres;
        return sum[C-1:0];
    endfunction

    always_comb
    begin
        o_sx_next = m_crd_reg.sx;
        o_sy_next = m_crd_reg.sy;
        o_ex_next = m_crd_reg.ex;
        o_ey_next = m_crd_reg.ey;
        if (m_use1_reg)
        begin
            o_sx_next = offset_point(m_crd_reg.sx, m_p1x_reg);
            o_sy_next = offset_point(m_crd_reg.sy, m_p1y_reg);
        end
        if (m_use2_reg)
        begin
            o_ex_next = offset_point(m_crd_reg.sx, m_p2x_reg);
            o_ey_next = offset_point(m_crd_reg.sy, m_p2y_reg);
        end
    end

    // Valid bits of the back stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            r_vld_reg <= dv_vld_reg[DIV_STAGES];
            e_vld_reg <= r_vld_reg;
            m_vld_reg <= e_vld_reg;
            o_vld_reg <= m_vld_reg;
        end
    end

    // Payload of the back stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_crd_reg <= dv_crd_reg[DIV_STAGES];
            for (int e = 0; e < NE; e++)
            begin
                r_edge_reg[e] <= dv_edge_reg[DIV_STAGES][e];
                r_u_reg[e]    <= r_u_next[e];
            end
            e_crd_reg  <= r_crd_reg;
            e_vis_reg  <= e_vis_next;
            e_u1_reg   <= e_u1_next;
            e_u2_reg   <= e_u2_next;
            m_crd_reg  <= e_crd_reg;
            m_vis_reg  <= e_vis_reg;
            m_use1_reg <= e_vis_reg && (e_u1_reg > U_ZERO);
            m_use2_reg <= e_vis_reg && (e_u2_reg < U_ONE);
            m_p1x_reg  <= e_u1_reg * e_crd_reg.dx;
            m_p1y_reg  <= e_u1_reg * e_crd_reg.dy;
            m_p2x_reg  <= e_u2_reg * e_crd_reg.dx;
            m_p2y_reg  <= e_u2_reg * e_crd_reg.dy;
            o_vis_reg  <= m_vis_reg;
            o_sx_reg   <= o_sx_next;
            o_sy_reg   <= o_sy_next;
            o_ex_reg   <= o_ex_next;
            o_ey_reg   <= o_ey_next;
        end
    end

    assign out_valid    = o_vld_reg;
    assign visible      = o_vis_reg;
    assign clip_start_x = o_sx_reg;
    assign clip_start_y = o_sy_reg;
    assign clip_end_x   = o_ex_reg;
    assign clip_end_y   = o_ey_reg;

    // A visible segment always has 0 <= u1 <= u2 <= 1 after the edge tests.
    `SRCLIP_ASSERT(a_param_order, e_vld_reg && e_vis_reg |-> (e_u1_reg >= U_ZERO) && (e_u1_reg <= e_u2_reg) && (e_u2_reg <= U_ONE), "clip parameters out of order")
    // A result in the multiply stage reaches the output on the next advance.
    `SRCLIP_ASSERT(a_result_flow, en && m_vld_reg |=> out_valid, "result lost between multiply and output")
    // Stalling the output must not drop a waiting result.
    `SRCLIP_ASSERT(a_hold_on_stall, out_valid && !out_ready |=> out_valid && $stable(visible), "waiting result changed under stall")

endmodule
